// ===== rtl/core/tts_pkg.sv =====
package tts_pkg;

	// field widths fixed by the item format
	localparam int ACTION_W = 2;
	localparam int TARGET_W = 4;
	localparam int STATUS_W = 3;
	localparam int ID_OUT_W = 4;

	localparam int MAX_THREADS_DEF = 16;

	// thread states
	localparam logic [1:0] T_DEAD     = 2'd0;
	localparam logic [1:0] T_RUNNABLE = 2'd1;
	localparam logic [1:0] T_WAITING  = 2'd2;

	// actions
	localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_YIELD  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_EXIT   = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_JOIN   = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NORUN    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DEADLOCK = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOSUCH   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

	// table write controls from the sequencer
	typedef struct packed {
		logic       st_we;     // write thread state
		logic [1:0] st_val;
		logic       wt_we;     // write waiter record
		logic       wt_valid;
	} tbl_cmd_t;

endpackage

// ===== rtl/core/tts_if.sv =====
interface tts_in_if;
	import tts_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [TARGET_W-1:0] target_id;

	modport source (output valid, output action, output target_id, input ready);
	modport sink   (input valid, input action, input target_id, output ready);
endinterface

interface tts_out_if;
	import tts_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                switched;
	logic [ID_OUT_W-1:0] running_id;
	logic [ID_OUT_W-1:0] new_id;

	modport source (output valid, output status, output switched, output running_id,
		output new_id, input ready);
	modport sink   (input valid, input status, input switched, input running_id,
		input new_id, output ready);
endinterface

// ===== rtl/core/tts_table.sv =====
module tts_table #(
	parameter int MAX_THREADS = tts_pkg::MAX_THREADS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tts_pkg::tbl_cmd_t                  cmd,
	input  logic [$clog2(MAX_THREADS)-1:0]     st_idx,
	input  logic [$clog2(MAX_THREADS)-1:0]     wt_idx,
	input  logic [$clog2(MAX_THREADS)-1:0]     wt_id,
	input  logic [$clog2(MAX_THREADS)-1:0]     rd_idx,
	output logic [1:0]                         rd_state,
	output logic                               rd_wvalid,
	output logic [$clog2(MAX_THREADS)-1:0]     rd_wid
);
	import tts_pkg::*;

	localparam int IdW = $clog2(MAX_THREADS);

	logic [1:0]     state_q  [MAX_THREADS];
	logic           wvalid_q [MAX_THREADS];
	logic [IdW-1:0] wid_q    [MAX_THREADS];

	// thread states: thread 0 lives after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_THREADS; i++) begin
				state_q[i] <= (i == 0) ? T_RUNNABLE : T_DEAD;
			end
		end else if (cmd.st_we) begin
			state_q[st_idx] <= cmd.st_val;
		end
	end

	// waiter valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_THREADS; i++) begin
				wvalid_q[i] <= 1'b0;
			end
		end else if (cmd.wt_we) begin
			wvalid_q[wt_idx] <= cmd.wt_valid;
		end
	end

	// waiter ids, only read behind a valid bit
	always_ff @(posedge clk) begin
		if (cmd.wt_we) begin
			wid_q[wt_idx] <= wt_id;
		end
	end

	assign rd_state  = state_q[rd_idx];
	assign rd_wvalid = wvalid_q[rd_idx];
	assign rd_wid    = wid_q[rd_idx];

endmodule

// ===== rtl/core/thread_table_scheduler.sv =====
// Channel  Dir  Fields                                   Transfer
// req      in   action, target_id                        req.valid && req.ready
// rsp      out  status, switched, running_id, new_id     rsp.valid && rsp.ready
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Create and rejected joins skip the scan: dispatch, then the result register.
// Yield, exit and accepted join run the round-robin scan through one shared
// table read port and comparator, one entry per cycle.
// A finished result waits in the output register; the next request is taken
// meanwhile, and its result is held back until rsp frees the register.
// Reset leaves thread 0 running, one thread created, no waiters.
module thread_table_scheduler #(
	parameter int MAX_THREADS = tts_pkg::MAX_THREADS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	tts_in_if.sink         req,
	tts_out_if.source      rsp
);
	import tts_pkg::*;

	localparam int IdW  = $clog2(MAX_THREADS);
	localparam int CntW = $clog2(MAX_THREADS + 1);
	localparam int CmpW = (CntW > TARGET_W) ? CntW : TARGET_W;

	// sequencer codes
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_WAKE  = 3'd2;
	localparam logic [2:0] S_SCAN1 = 3'd3;
	localparam logic [2:0] S_SCAN2 = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0]          state_q, state_d;
	logic [ACTION_W-1:0] act_q;
	logic [TARGET_W-1:0] tgt_q;
	logic [IdW-1:0]      cur_q, before_q;
	logic [CntW-1:0]     cnt_q;
	logic [CntW-1:0]     scan_q;
	logic [STATUS_W-1:0] status_q;
	logic [CntW-1:0]     newid_q;
	logic                wk_valid_q;
	logic [IdW-1:0]      wk_id_q;

	logic                ov_q;
	logic [STATUS_W-1:0] o_status_q;
	logic                o_switched_q;
	logic [ID_OUT_W-1:0] o_running_q;
	logic [ID_OUT_W-1:0] o_newid_q;

	tbl_cmd_t       cmd;
	logic [IdW-1:0] st_idx, wt_idx, rd_idx;
	logic [1:0]     rd_state;
	logic           rd_wvalid;
	logic [IdW-1:0] rd_wid;

	logic [CmpW-1:0] tgt_w, cur_w, cnt_w;
	logic [IdW-1:0]  tgt_idx, cnt_idx, scan_idx;
	logic            full, scan_hit, out_free;

	assign tgt_w    = CmpW'(tgt_q);
	assign cur_w    = CmpW'(cur_q);
	assign cnt_w    = CmpW'(cnt_q);
	assign tgt_idx  = tgt_w[IdW-1:0];
	assign cnt_idx  = cnt_q[IdW-1:0];
	assign scan_idx = scan_q[IdW-1:0];
	assign full     = (cnt_q >= CntW'(MAX_THREADS));
	assign scan_hit = (rd_state == T_RUNNABLE);
	assign out_free = !ov_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);

	tts_table #(.MAX_THREADS(MAX_THREADS)) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st_idx    (st_idx),
		.wt_idx    (wt_idx),
		.wt_id     (cur_q),
		.rd_idx    (rd_idx),
		.rd_state  (rd_state),
		.rd_wvalid (rd_wvalid),
		.rd_wid    (rd_wid)
	);

	// table access and next state
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		st_idx  = cur_q;
		wt_idx  = cnt_idx;
		rd_idx  = cur_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_DISP;
			end
			S_DISP: begin
				case (act_q)
					ACT_CREATE: begin
						state_d = S_RESP;
						if (!full) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = T_RUNNABLE;
							st_idx     = cnt_idx;
							cmd.wt_we  = 1'b1;
						end
					end
					ACT_YIELD: state_d = S_SCAN1;
					ACT_EXIT: begin
						cmd.st_we  = 1'b1;
						cmd.st_val = T_DEAD;
						state_d    = S_WAKE;
					end
					default: begin
						rd_idx  = tgt_idx;
						state_d = S_RESP;
						if (tgt_w != cur_w && tgt_w < cnt_w && rd_state != T_DEAD
							&& !rd_wvalid) begin
							cmd.st_we    = 1'b1;
							cmd.st_val   = T_WAITING;
							cmd.wt_we    = 1'b1;
							cmd.wt_valid = 1'b1;
							wt_idx       = tgt_idx;
							state_d      = S_SCAN1;
						end
					end
				endcase
			end
			S_WAKE: begin
				cmd.st_we  = wk_valid_q;
				cmd.st_val = T_RUNNABLE;
				st_idx     = wk_id_q;
				state_d    = S_SCAN1;
			end
			S_SCAN1: begin
				rd_idx = scan_idx;
				if (scan_q >= cnt_q) state_d = S_SCAN2;
				else if (scan_hit) state_d = S_RESP;
			end
			S_SCAN2: begin
				rd_idx = scan_idx;
				if (scan_q > CntW'(cur_q) || scan_hit) state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			cnt_q   <= CntW'(1);
		end else begin
			state_q <= state_d;
			if (state_q == S_DISP && act_q == ACT_CREATE && !full) begin
				cnt_q <= cnt_q + CntW'(1);
			end
			if ((state_q == S_SCAN1 && scan_q < cnt_q && scan_hit)
				|| (state_q == S_SCAN2 && scan_q <= CntW'(cur_q) && scan_hit)) begin
				cur_q <= scan_idx;
			end
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q    <= req.action;
			tgt_q    <= req.target_id;
			before_q <= cur_q;
			status_q <= ST_OK;
			newid_q  <= '0;
		end
		if (state_q == S_DISP) begin
			scan_q     <= CntW'(cur_q) + CntW'(1);
			wk_valid_q <= rd_wvalid;
			wk_id_q    <= rd_wid;
			case (act_q)
				ACT_CREATE: begin
					if (full) status_q <= ST_FULL;
					else newid_q <= cnt_q;
				end
				ACT_JOIN: begin
					if (tgt_w == cur_w) status_q <= ST_DEADLOCK;
					else if (tgt_w >= cnt_w) status_q <= ST_NOSUCH;
					else if (rd_state == T_DEAD || rd_wvalid) status_q <= ST_INVALID;
				end
				default: ;
			endcase
		end
		if (state_q == S_SCAN1) begin
			if (scan_q >= cnt_q) scan_q <= '0;
			else scan_q <= scan_q + CntW'(1);
		end
		if (state_q == S_SCAN2) begin
			scan_q <= scan_q + CntW'(1);
			if (scan_q > CntW'(cur_q)) status_q <= ST_NORUN;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			o_status_q   <= status_q;
			o_switched_q <= (cur_q != before_q);
			o_running_q  <= ID_OUT_W'(cur_q);
			o_newid_q    <= ID_OUT_W'(newid_q);
		end
	end

	assign rsp.valid      = ov_q;
	assign rsp.status     = o_status_q;
	assign rsp.switched   = o_switched_q;
	assign rsp.running_id = o_running_q;
	assign rsp.new_id     = o_newid_q;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= CntW'(MAX_THREADS))
		else $error("thread count out of range");

	a_scan_above_cur: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN1 |-> scan_q > CntW'(cur_q))
		else $error("first scan pass started at or below current thread");

	a_switch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.switched |-> rsp.status == ST_OK)
		else $error("thread switch reported with failing status");

	a_req_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while busy");

endmodule

// ===== sim/tb_thread_table_scheduler.sv =====
module tb_thread_table_scheduler;
	import tts_pkg::*;

	localparam int NTHR           = MAX_THREADS_DEF;
	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 4;
	localparam int RAND_PER_PHASE = 125;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = NTHR + 10;
	localparam int LIMIT_CYCLES   = 400000;

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [TARGET_W-1:0] target_id;
	} sched_req_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic                switched;
		logic [ID_OUT_W-1:0] running_id;
		logic [ID_OUT_W-1:0] new_id;
	} sched_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	tts_in_if  req_if ();
	tts_out_if rsp_if ();

	thread_table_scheduler #(
		.MAX_THREADS (NTHR)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// predicted thread table
	logic [1:0]          thr_state [NTHR];
	logic                wait_vld  [NTHR];
	logic [TARGET_W-1:0] wait_id   [NTHR];
	int unsigned         cur_id;
	int unsigned         thr_count;

	sched_req_t  pending_reqs [$];
	sched_rsp_t  exp_results  [$];
	int unsigned req_offers    = 0;
	int unsigned req_accepts   = 0;
	int unsigned rsp_seen      = 0;
	int unsigned err_cnt       = 0;
	int unsigned in_idle_pct   = 0;
	int unsigned out_stall_pct = 0;
	int unsigned rsp_hold_left = 0;
	int unsigned action_seen [4];
	int unsigned status_seen [8];

	always #(CLK_HALF) clk = ~clk;

	function automatic void sched_reset();
		for (int i = 0; i < NTHR; i++) begin
			thr_state[i] = T_DEAD;
			wait_vld[i]  = 1'b0;
			wait_id[i]   = '0;
		end
		thr_state[0] = T_RUNNABLE;
		cur_id       = 0;
		thr_count    = 1;
	endfunction

	// round-robin: first active above current, else wrap to first at or below
	function automatic logic [STATUS_W-1:0] rr_pick();
		for (int i = cur_id + 1; i < thr_count && i < NTHR; i++) begin
			if (thr_state[i] == T_RUNNABLE) begin
				cur_id = i;
				return ST_OK;
			end
		end
		for (int i = 0; i <= cur_id && i < NTHR; i++) begin
			if (thr_state[i] == T_RUNNABLE) begin
				cur_id = i;
				return ST_OK;
			end
		end
		return ST_NORUN;
	endfunction

	// applies one request to the predicted table and returns its result
	function automatic sched_rsp_t sched_predict(sched_req_t r);
		sched_rsp_t  res;
		int unsigned prev;
		int unsigned tgt;
		prev       = cur_id;
		tgt        = 32'(r.target_id);
		res.status = ST_OK;
		res.new_id = '0;
		case (r.action)
			ACT_CREATE: begin
				if (thr_count >= NTHR) begin
					res.status = ST_FULL;
				end else begin
					res.new_id           = ID_OUT_W'(thr_count);
					thr_state[thr_count] = T_RUNNABLE;
					wait_vld[thr_count]  = 1'b0;
					wait_id[thr_count]   = '0;
					thr_count++;
				end
			end
			ACT_YIELD: begin
				res.status = rr_pick();
			end
			ACT_EXIT: begin
				thr_state[cur_id] = T_DEAD;
				if (wait_vld[cur_id])
					thr_state[wait_id[cur_id]] = T_RUNNABLE;
				res.status = rr_pick();
			end
			default: begin
				if (tgt == cur_id) begin
					res.status = ST_DEADLOCK;
				end else if (tgt >= thr_count) begin
					res.status = ST_NOSUCH;
				end else if (thr_state[tgt] == T_DEAD || wait_vld[tgt]) begin
					res.status = ST_INVALID;
				end else begin
					thr_state[cur_id] = T_WAITING;
					wait_vld[tgt]     = 1'b1;
					wait_id[tgt]      = TARGET_W'(cur_id);
					res.status        = rr_pick();
				end
			end
		endcase
		res.switched   = (cur_id != prev);
		res.running_id = ID_OUT_W'(cur_id);
		return res;
	endfunction

	// mostly yields and well-formed joins; creates and exits kept sparse
	// so the table stays alive for a good part of the run
	function automatic sched_req_t gen_request();
		sched_req_t  r;
		int unsigned pick;
		int unsigned cands [$];
		bit          any_active;
		r.target_id = TARGET_W'($urandom_range(15));
		any_active  = 1'b0;
		for (int i = 0; i < thr_count; i++) begin
			if (thr_state[i] == T_RUNNABLE)
				any_active = 1'b1;
			if (i != cur_id && thr_state[i] != T_DEAD && !wait_vld[i])
				cands.push_back(i);
		end
		pick = $urandom_range(99);
		if (!any_active && pick < 50) begin
			r.action = ACT_EXIT;
		end else if (pick < 6) begin
			r.action = ACT_CREATE;
		end else if (pick < 10) begin
			r.action = ACT_EXIT;
		end else if (pick < 40) begin
			r.action = ACT_JOIN;
			if (cands.size() > 0 && $urandom_range(9) < 7)
				r.target_id = TARGET_W'(cands[$urandom_range(cands.size() - 1)]);
		end else begin
			r.action = ACT_YIELD;
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	task automatic queue_req(logic [ACTION_W-1:0] act, logic [TARGET_W-1:0] tgt);
		sched_req_t r;
		r.action    = act;
		r.target_id = tgt;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drain();
		while (pending_reqs.size() > 0 || exp_results.size() > 0 || req_if.valid)
			@(negedge clk);
	endtask

	// request driver: hold the item until its transfer, then offer the next
	always @(negedge clk) begin : req_driver
		sched_req_t nxt;
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_accepts == req_offers) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
				nxt = pending_reqs.pop_front();
				req_if.valid     <= 1'b1;
				req_if.action    <= nxt.action;
				req_if.target_id <= nxt.target_id;
				req_offers++;
			end else begin
				req_if.valid     <= 1'b0;
				req_if.action    <= ACTION_W'($urandom);
				req_if.target_id <= TARGET_W'($urandom);
			end
		end
	end

	// request transfers feed the predictor
	always @(posedge clk) begin : req_monitor
		sched_req_t r;
		if (arst_n && req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
			r.action    = req_if.action;
			r.target_id = req_if.target_id;
			exp_results.push_back(sched_predict(r));
			action_seen[r.action]++;
			req_accepts++;
		end
	end

	// response ready: long hold-off when requested, else random stalls
	always @(negedge clk) begin : rsp_driver
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (rsp_hold_left > 0) begin
			rsp_if.ready <= 1'b0;
			rsp_hold_left--;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	// response transfers checked against the oldest prediction
	always @(posedge clk) begin : rsp_monitor
		sched_rsp_t want;
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (exp_results.size() == 0) begin
				$error("unexpected result: status %0d running_id %0d",
					rsp_if.status, rsp_if.running_id);
				err_cnt++;
			end else begin
				want = exp_results.pop_front();
				check_field("status", 4'(want.status), 4'(rsp_if.status));
				check_field("switched", 4'(want.switched), 4'(rsp_if.switched));
				check_field("running_id", want.running_id, rsp_if.running_id);
				check_field("new_id", want.new_id, rsp_if.new_id);
				status_seen[want.status]++;
			end
			rsp_seen++;
		end
	end

	initial begin : stimulus
		int unsigned idle_in  [4];
		int unsigned idle_out [4];
		idle_in  = '{0, 79, 0, 35};
		idle_out = '{0, 0, 79, 35};
		arst_n           = 1'b0;
		req_if.valid     = 1'b0;
		req_if.action    = ACT_CREATE;
		req_if.target_id = '0;
		rsp_if.ready     = 1'b0;
		for (int i = 0; i < 4; i++)
			action_seen[i] = 0;
		for (int i = 0; i < 8; i++)
			status_seen[i] = 0;
		sched_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: lone thread yielding to itself, join rejections,
		// accepted joins, no runnable thread, exit of a dead thread
		// and join on a dead target
		queue_req(ACT_YIELD,  4'd0);
		queue_req(ACT_JOIN,   4'd0);
		queue_req(ACT_JOIN,   4'd15);
		queue_req(ACT_JOIN,   4'd9);
		queue_req(ACT_CREATE, 4'd15);
		queue_req(ACT_CREATE, 4'd0);
		queue_req(ACT_JOIN,   4'd1);
		queue_req(ACT_JOIN,   4'd1);
		queue_req(ACT_JOIN,   4'd0);
		queue_req(ACT_JOIN,   4'd1);
		queue_req(ACT_YIELD,  4'd15);
		queue_req(ACT_CREATE, 4'd0);
		queue_req(ACT_YIELD,  4'd0);
		queue_req(ACT_EXIT,   4'd15);
		queue_req(ACT_JOIN,   4'd3);
		queue_req(ACT_EXIT,   4'd0);
		queue_req(ACT_YIELD,  4'd0);
		queue_req(ACT_EXIT,   4'd0);
		queue_req(ACT_EXIT,   4'd0);
		queue_req(ACT_YIELD,  4'd15);
		queue_req(ACT_JOIN,   4'd2);
		queue_req(ACT_CREATE, 4'd0);
		queue_req(ACT_YIELD,  4'd0);
		wait_drain();

		// random phases with different idle and stall rates
		for (int p = 0; p < 4; p++) begin
			in_idle_pct   = idle_in[p];
			out_stall_pct = idle_out[p];
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				while (pending_reqs.size() > 0)
					@(negedge clk);
				if (p == 1 && n == 20)
					rsp_hold_left = LONG_HOLD;
				if ($urandom_range(49) == 0)
					wait_drain();
				pending_reqs.push_back(gen_request());
			end
			wait_drain();
		end

		// make sure creates run into the full table
		for (int i = 0; i < NTHR; i++)
			queue_req(ACT_CREATE, TARGET_W'($urandom_range(15)));
		wait_drain();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Requests: %0d (create %0d, yield %0d, exit %0d, join %0d), results %0d",
			req_accepts, action_seen[ACT_CREATE], action_seen[ACT_YIELD],
			action_seen[ACT_EXIT], action_seen[ACT_JOIN], rsp_seen);
		$display("Status mix: ok %0d, norun %0d, deadlock %0d, nosuch %0d, invalid %0d, full %0d",
			status_seen[ST_OK], status_seen[ST_NORUN], status_seen[ST_DEADLOCK],
			status_seen[ST_NOSUCH], status_seen[ST_INVALID], status_seen[ST_FULL]);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
